// ===== sv/ccls_pkg.sv =====
// ccls_pkg: types and fixed constants of the clip chain lane sequencer.
// No dependencies; used by clip_chain_lane_sequencer_core, ccls_checker and tb.
package ccls_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned MaxLanes   = 16;

  localparam int unsigned EntryW  = 4;
  localparam int unsigned LaneW   = 4;
  localparam int unsigned FramesW = 30;
  localparam int unsigned FrameW  = 64;
  localparam int unsigned CountW  = 5;
  localparam int unsigned MaskW   = 16;

  // Function codes of an input transaction
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_CHAIN_ENABLE = 2'd0;
  localparam logic [1:0] REG_ENTRY_COUNT  = 2'd1;
  localparam logic [1:0] REG_LANE_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               func;
    logic [EntryW-1:0]  entry_index;
    logic [LaneW-1:0]   entry_lane;
    logic [FramesW-1:0] entry_frames;
    logic               running;
    logic [FrameW-1:0]  tick_frame;
  } in_item_t;

  typedef struct packed {
    logic [LaneW-1:0]  open_lane;
    logic [EntryW-1:0] active_position;
    logic [MaskW-1:0]  mute_mask;
    logic [MaskW-1:0]  restart_mask;
    logic [FrameW-1:0] next_boundary;
    logic              boundary_valid;
  } out_item_t;

endpackage

// ===== sv/clip_chain_lane_sequencer_core.sv =====
// clip_chain_lane_sequencer_core: chain table, boundary stepping and mute masks.
// Depends on ccls_pkg (types, constants, state encoding).
//
// Usage: a transaction is accepted when start is high and busy is low. A write
// transaction (func = 1) loads one chain entry and restarts the chain; its result
// appears on out_data with out_valid in the cycle after acceptance. A tick that finds
// the chain inactive (not running, disabled, or zero entries or lanes) also answers
// in the cycle after acceptance. A tick that syncs the chain passes through ST_FINISH
// before its result is registered. A synced tick walks the chain with one shared 64-bit
// compare and add, one entry transition per clock, in ST_STEP and then ST_FINISH; the
// transitions are at most MAX_STEPS_PER_TICK. busy is high meanwhile.
// out_valid is a single-cycle strobe and the receiver cannot hold it off; busy drops
// in the strobe cycle, so the next transaction may start while a result is shown.
// Writes to the mapped configuration registers take effect at once and restart the
// chain; issue them only while the block is idle.
module clip_chain_lane_sequencer_core #(
  parameter int unsigned MAX_STEPS_PER_TICK = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ccls_pkg::in_item_t            in_data,
  output logic                          out_valid,
  output ccls_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [ccls_pkg::CountW-1:0]   cfg_data
);
  import ccls_pkg::*;

  localparam int unsigned StepW = $clog2(MAX_STEPS_PER_TICK + 1);
  localparam logic [StepW-1:0] StepMax = StepW'(MAX_STEPS_PER_TICK);

  // Chain table, reset to lane 0 / one frame per entry
  logic [LaneW-1:0]   lane_table_r  [MaxEntries];
  logic [FramesW-1:0] frames_table_r[MaxEntries];

  state_t             state_r, state_nxt;
  logic               chain_enable_r;
  logic [CountW-1:0]  entry_count_r, lane_count_r;
  logic [EntryW-1:0]  cur_entry_r, cur_entry_nxt;
  logic [FrameW-1:0]  boundary_r, boundary_nxt;
  logic               synced_r, synced_nxt;
  logic [MaskW-1:0]   muted_r, muted_nxt;
  logic [FrameW-1:0]  frame_r;
  logic [StepW-1:0]   steps_r, steps_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               accept;
  logic [CountW-1:0]  ne, nl;
  logic [MaskW-1:0]   range_mask;
  logic               chain_active;
  logic               advance;
  logic [EntryW-1:0]  step_entry;
  logic [LaneW-1:0]   wr_lane;
  logic [FramesW-1:0] wr_frames;
  logic [LaneW-1:0]   act_lane;
  logic [MaskW-1:0]   entry_mute;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Effective counts saturate at the table / lane sizes
  assign ne = (entry_count_r > CountW'(MaxEntries)) ? CountW'(MaxEntries) : entry_count_r;
  assign nl = (lane_count_r > CountW'(MaxLanes)) ? CountW'(MaxLanes) : lane_count_r;
  assign range_mask = MaskW'((17'd1 << nl) - 17'd1);

  assign chain_active = in_data.running && chain_enable_r && (ne != '0) && (nl != '0);

  // Write path: clamp the lane to lanes present, store zero duration as one
  always_comb begin
    if (nl == '0) begin
      wr_lane = '0;
    end else if ({1'b0, in_data.entry_lane} >= nl) begin
      wr_lane = LaneW'(nl - CountW'(1));
    end else begin
      wr_lane = in_data.entry_lane;
    end
    wr_frames = (in_data.entry_frames == '0) ? FramesW'(1) : in_data.entry_frames;
  end

  // Shared step unit: one compare and one add per cycle
  assign advance    = (frame_r >= boundary_r) && (steps_r < StepMax);
  assign step_entry = ({1'b0, cur_entry_r} + CountW'(1) == ne) ? '0 : cur_entry_r + EntryW'(1);

  // Mute masks for the active entry
  always_comb begin
    act_lane = lane_table_r[cur_entry_r];
    if ({1'b0, act_lane} >= nl) begin
      act_lane = LaneW'(nl - CountW'(1));
    end
    entry_mute = range_mask & ~(MaskW'(1) << act_lane);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.func == FUNC_TICK) && chain_active) begin
          state_nxt = synced_r ? ST_STEP : ST_FINISH;
        end
      end
      ST_STEP: begin
        if (!advance) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    cur_entry_nxt = cur_entry_r;
    boundary_nxt  = boundary_r;
    synced_nxt    = synced_r;
    muted_nxt     = muted_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.open_lane       = '0;
          out_nxt.active_position = '0;
          out_nxt.restart_mask    = '0;
          out_nxt.next_boundary   = '1;
          out_nxt.boundary_valid  = 1'b0;
          out_nxt.mute_mask       = muted_r;
          steps_nxt               = '0;
          if (in_data.func == FUNC_WRITE) begin
            synced_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
          end else if (!chain_active) begin
            synced_nxt        = 1'b0;
            muted_nxt         = muted_r & ~range_mask;
            out_nxt.mute_mask = muted_r & ~range_mask;
            out_valid_nxt     = 1'b1;
          end else if (!synced_r) begin
            cur_entry_nxt = '0;
            boundary_nxt  = in_data.tick_frame + FrameW'(frames_table_r[0]);
            synced_nxt    = 1'b1;
          end
        end
        if (cfg_we && (cfg_index == REG_CHAIN_ENABLE || cfg_index == REG_ENTRY_COUNT
                       || cfg_index == REG_LANE_COUNT)) begin
          synced_nxt = 1'b0;
        end
      end
      ST_STEP: begin
        if (advance) begin
          steps_nxt     = steps_r + StepW'(1);
          cur_entry_nxt = step_entry;
          boundary_nxt  = boundary_r + FrameW'(frames_table_r[step_entry]);
        end
      end
      ST_FINISH: begin
        muted_nxt               = (muted_r & ~range_mask) | entry_mute;
        out_nxt.open_lane       = act_lane;
        out_nxt.active_position = cur_entry_r;
        out_nxt.mute_mask       = (muted_r & ~range_mask) | entry_mute;
        out_nxt.restart_mask    = muted_r & range_mask & ~entry_mute;
        out_nxt.next_boundary   = boundary_r;
        out_nxt.boundary_valid  = 1'b1;
        out_valid_nxt           = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      chain_enable_r <= 1'b0;
      entry_count_r  <= '0;
      lane_count_r   <= '0;
      cur_entry_r    <= '0;
      boundary_r     <= '0;
      synced_r       <= 1'b0;
      muted_r        <= '0;
      steps_r        <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < MaxEntries; i++) begin
        lane_table_r[i]   <= '0;
        frames_table_r[i] <= FramesW'(1);
      end
    end else begin
      state_r     <= state_nxt;
      cur_entry_r <= cur_entry_nxt;
      boundary_r  <= boundary_nxt;
      synced_r    <= synced_nxt;
      muted_r     <= muted_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHAIN_ENABLE: chain_enable_r <= cfg_data[0];
          REG_ENTRY_COUNT:  entry_count_r  <= cfg_data;
          REG_LANE_COUNT:   lane_count_r   <= cfg_data;
          default: ;
        endcase
      end
      if (accept && (in_data.func == FUNC_WRITE)) begin
        lane_table_r[in_data.entry_index]   <= wr_lane;
        frames_table_r[in_data.entry_index] <= wr_frames;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      frame_r <= in_data.tick_frame;
    end
  end

endmodule

// ===== dv/ccls_checker.sv =====
// ccls_checker: passive scoreboard for the clip chain lane sequencer; mirrors the chain
// table, boundary stepping and mute masks, and compares every result transaction.
// Depends on ccls_pkg (transaction types, register indexes, table sizes).
module ccls_checker #(
  parameter int unsigned MAX_STEPS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  ccls_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  ccls_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ccls_pkg::CountW-1:0] cfg_data,
  output int                          mismatch_cnt,
  output int                          open_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import ccls_pkg::*;

  logic [LaneW-1:0]   lane_tab   [MaxEntries];
  logic [FramesW-1:0] frames_tab [MaxEntries];
  int unsigned        cur_entry;
  logic [FrameW-1:0]  boundary;
  logic               synced;
  logic [MaskW-1:0]   muted;
  logic               chain_en;
  logic [CountW-1:0]  entry_cnt;
  logic [CountW-1:0]  lane_cnt;
  out_item_t          expected_views[$];

  initial begin
    mismatch_cnt = 0;
    open_cnt     = 0;
  end

  // Applies one transaction to the mirrored state and returns the result it must give.
  function automatic out_item_t advance_chain(in_item_t it);
    out_item_t   r;
    int unsigned nl;
    int unsigned ne;
    int unsigned lane;
    int unsigned steps;
    logic [MaskW-1:0] lane_span;
    logic [MaskW-1:0] entry_mute;
    nl = (lane_cnt > MaxLanes) ? MaxLanes : lane_cnt;
    ne = (entry_cnt > MaxEntries) ? MaxEntries : entry_cnt;
    r = '0;
    r.next_boundary = '1;
    lane_span = MaskW'((17'd1 << nl) - 17'd1);

    if (it.func == FUNC_WRITE) begin
      lane = it.entry_lane;
      if (nl == 0) lane = 0;
      else if (lane > nl - 1) lane = nl - 1;
      lane_tab[it.entry_index]   = LaneW'(lane);
      frames_tab[it.entry_index] = (it.entry_frames == '0) ? FramesW'(1) : it.entry_frames;
      synced = 1'b0;
      r.mute_mask = muted;
      return r;
    end

    if (!it.running || !chain_en || ne == 0 || nl == 0) begin
      synced = 1'b0;
      muted &= ~lane_span;
      r.mute_mask = muted;
      return r;
    end

    if (!synced) begin
      cur_entry = 0;
      boundary  = it.tick_frame + FrameW'(frames_tab[0]);
      synced    = 1'b1;
    end else begin
      // Boundary arithmetic wraps at 64 bits; the walk stops at the step cap.
      steps = 0;
      cur_entry = cur_entry % ne;
      while (it.tick_frame >= boundary && steps < MAX_STEPS) begin
        steps++;
        cur_entry = (cur_entry + 1) % ne;
        boundary += FrameW'(frames_tab[cur_entry]);
      end
    end

    lane = lane_tab[cur_entry];
    if (lane > nl - 1) lane = nl - 1;
    entry_mute = lane_span & ~(MaskW'(1) << lane);
    r.restart_mask    = muted & lane_span & ~entry_mute;
    muted             = (muted & ~lane_span) | entry_mute;
    r.open_lane       = LaneW'(lane);
    r.active_position = EntryW'(cur_entry);
    r.mute_mask       = muted;
    r.next_boundary   = boundary;
    r.boundary_valid  = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, seen, want);
  endtask

  task automatic check_view(input out_item_t seen, input out_item_t want);
    if (seen.open_lane !== want.open_lane)
      report_mismatch("open_lane", 64'(seen.open_lane), 64'(want.open_lane));
    if (seen.active_position !== want.active_position)
      report_mismatch("active_position", 64'(seen.active_position),
                      64'(want.active_position));
    if (seen.mute_mask !== want.mute_mask)
      report_mismatch("mute_mask", 64'(seen.mute_mask), 64'(want.mute_mask));
    if (seen.restart_mask !== want.restart_mask)
      report_mismatch("restart_mask", 64'(seen.restart_mask), 64'(want.restart_mask));
    if (seen.next_boundary !== want.next_boundary)
      report_mismatch("next_boundary", seen.next_boundary, want.next_boundary);
    if (seen.boundary_valid !== want.boundary_valid)
      report_mismatch("boundary_valid", 64'(seen.boundary_valid), 64'(want.boundary_valid));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxEntries; i++) begin
        lane_tab[i]   = '0;
        frames_tab[i] = FramesW'(1);
      end
      cur_entry = 0;
      boundary  = '0;
      synced    = 1'b0;
      muted     = '0;
      chain_en  = 1'b0;
      entry_cnt = '0;
      lane_cnt  = '0;
      expected_views.delete();
    end else begin
      // Any write to a known register restarts the chain.
      if (cfg_we) begin
        case (cfg_index)
          REG_CHAIN_ENABLE: begin
            chain_en = cfg_data[0];
            synced   = 1'b0;
          end
          REG_ENTRY_COUNT: begin
            entry_cnt = cfg_data;
            synced    = 1'b0;
          end
          REG_LANE_COUNT: begin
            lane_cnt = cfg_data;
            synced   = 1'b0;
          end
          default: ;
        endcase
      end
      // The result of one transaction may share an edge with the next acceptance.
      if (out_valid) begin
        if (expected_views.size() == 0)
          report_mismatch("result with nothing pending", out_data.next_boundary, '0);
        else
          check_view(out_data, expected_views.pop_front());
      end
      if (start && !busy) expected_views.push_back(advance_chain(in_data));
    end
    open_cnt = expected_views.size();
  end

endmodule

// ===== dv/tb.sv =====
// tb: top of the clip chain lane sequencer testbench; drives transactions and config
// writes, instantiates the core and ccls_checker, and prints the verdict.
// Depends on ccls_pkg, clip_chain_lane_sequencer_core and ccls_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccls_pkg::*;

  localparam int unsigned STEP_CAP    = 64;
  localparam int unsigned QUIET_LIMIT = 2000;  // far above the worst gap plus a capped walk
  localparam int unsigned PHASES      = 14;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam logic [1:0]  REG_SPARE   = 2'd3;  // unmapped index, must be ignored

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  in_item_t          in_data   = '0;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [CountW-1:0] cfg_data  = '0;

  int                mismatch_cnt;
  int                open_cnt;
  int unsigned       issued       = 0;
  int unsigned       answered     = 0;
  int unsigned       quiet_cycles = 0;
  bit                gaps_on      = 1'b1;
  int unsigned       cur_entries  = 0;
  logic [FrameW-1:0] frame_now;

  clip_chain_lane_sequencer_core #(
    .MAX_STEPS_PER_TICK(STEP_CAP)
  ) uut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  ccls_checker #(
    .MAX_STEPS(STEP_CAP)
  ) u_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data, .mismatch_cnt, .open_cnt
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Every transaction answers exactly once, so results seen track what is still in flight.
  always @(posedge clk) begin
    if (rst_n && out_valid) answered <= answered + 1;
  end

  // Watchdog: any handshake, result or config write counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hands one transaction to the core after an optional random gap. Returns once the core
  // has taken it and busy is low; start stays high, so a back-to-back item needs no re-raise.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // Unused fields carry random bits so every input bit toggles.
  function automatic in_item_t noise_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  task automatic send_tick(input logic run, input logic [FrameW-1:0] frame);
    in_item_t it;
    it = noise_item();
    it.func       = FUNC_TICK;
    it.running    = run;
    it.tick_frame = frame;
    send_item(it);
  endtask

  task automatic send_write(input logic [EntryW-1:0] idx, input logic [LaneW-1:0] lane,
                            input logic [FramesW-1:0] frames);
    in_item_t it;
    it = noise_item();
    it.func         = FUNC_WRITE;
    it.entry_index  = idx;
    it.entry_lane   = lane;
    it.entry_frames = frames;
    send_item(it);
  endtask

  // Drops start and waits until every transaction has answered; must be entered in the
  // same step as the last acceptance so no stale transaction gets taken twice.
  task automatic wait_idle();
    start <= 1'b0;
    while (issued != answered) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Caller lowers cfg_we after the last write of a burst.
  task automatic write_reg(input logic [1:0] idx, input logic [CountW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic en, input logic [CountW-1:0] ne,
                            input logic [CountW-1:0] nl);
    wait_idle();
    write_reg(REG_CHAIN_ENABLE, {4'($urandom), en});  // only bit 0 matters
    write_reg(REG_ENTRY_COUNT, ne);
    write_reg(REG_LANE_COUNT, nl);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 5'($urandom));
    cfg_we <= 1'b0;
    cur_entries = (ne > MaxEntries) ? MaxEntries : ne;
  endtask

  // Durations: mostly short so ticks walk several entries, with zero and full-width cases.
  function automatic logic [FramesW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return FramesW'($urandom);
    if (r < 22) return FramesW'($urandom_range(20, 300));
    return FramesW'($urandom_range(1, 8));
  endfunction

  // One phase: configure, load the table, then a running transport with some noise.
  task automatic run_phase(input logic en, input logic [CountW-1:0] ne,
                           input logic [CountW-1:0] nl);
    int unsigned r;
    int unsigned n_load;
    set_config(en, ne, nl);
    gaps_on = ($urandom_range(0, 3) != 0);
    n_load = (cur_entries == 0) ? $urandom_range(1, 4) : cur_entries;
    for (int i = 0; i < n_load; i++) send_write(EntryW'(i), LaneW'($urandom), pick_len());

    r = $urandom_range(0, 9);
    if (r < 2) frame_now = '1 - FrameW'($urandom_range(0, 400));  // wraps during the phase
    else if (r < 5) frame_now = {$urandom(), $urandom()};
    else frame_now = FrameW'($urandom_range(0, 5000));

    for (int k = n_load; k < PHASE_ITEMS; k++) begin
      // A write to the unmapped index mid-run must not break sync.
      if (k == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(REG_SPARE, 5'($urandom));
        cfg_we <= 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_tick(1'b0, {$urandom(), $urandom()});
      end else if (r < 13) begin
        send_write(EntryW'($urandom), LaneW'($urandom), pick_len());
      end else begin
        if (r < 16) frame_now = {$urandom(), $urandom()};
        else if (r < 18) frame_now += FrameW'($urandom()) << 8;  // long jump, hits step cap
        else frame_now += FrameW'($urandom_range(0, 12));
        send_tick(1'b1, frame_now);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset-state tick, clamping, zero and full durations, sync, stepping,
    // step cap, 64-bit wrap, saturated counts, zero entries, zero lanes, disabled chain.
    send_tick(1'b1, 64'd0);
    set_config(1'b1, 5'd4, 5'd4);
    send_write(4'd0, 4'd15, 30'd0);
    send_write(4'd1, 4'd1, '1);
    send_write(4'd2, 4'd2, 30'd5);
    send_write(4'd3, 4'd0, 30'd2);
    send_tick(1'b0, 64'd0);
    send_tick(1'b1, 64'd100);
    send_tick(1'b1, 64'd100);
    send_tick(1'b1, 64'd101);
    send_tick(1'b1, '1 - 64'd15);
    send_tick(1'b1, '1 - 64'd15);
    send_write(4'd0, 4'd3, 30'd1);
    send_tick(1'b1, '1 - 64'd1);
    send_tick(1'b1, '1);
    set_config(1'b1, 5'd31, 5'd31);
    send_write(4'd15, 4'd15, 30'd7);
    send_tick(1'b1, 64'd0);
    send_tick(1'b1, 64'd40);
    set_config(1'b1, 5'd0, 5'd5);
    send_tick(1'b1, 64'd50);
    set_config(1'b1, 5'd5, 5'd0);
    send_write(4'd4, 4'd9, 30'd3);
    send_tick(1'b1, 64'd60);
    set_config(1'b0, 5'd8, 5'd8);
    send_tick(1'b1, 64'd70);

    // Random phases: extremes first, then random settings.
    run_phase(1'b1, 5'd16, 5'd16);
    run_phase(1'b1, 5'd1, 5'd1);
    run_phase(1'b1, 5'd31, 5'd31);
    run_phase(1'b1, 5'd16, 5'd1);
    run_phase(1'b1, 5'd2, 5'd16);
    run_phase(1'b0, 5'd8, 5'd8);
    run_phase(1'b1, 5'd0, 5'd4);
    run_phase(1'b1, 5'd6, 5'd0);
    for (int p = 8; p < PHASES; p++)
      run_phase($urandom_range(0, 7) != 0,
                ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)),
                ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16)));

    // Drain, then allow one full capped walk before the verdict.
    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0 && open_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
